@@ rtl/ssdcf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssdcf_pkg;

  typedef enum logic [1:0] {
    OP_DECIMAL = 2'd0,
    OP_RAW     = 2'd1,
    OP_POWER   = 2'd2,
    OP_BRIGHT  = 2'd3
  } op_t;

  localparam logic [7:0] CMD_DATA    = 8'h40;
  localparam logic [7:0] CMD_ADDRESS = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY = 8'h80;
  localparam logic [7:0] SEG_MINUS   = 8'h40;
  localparam logic [7:0] SEG_DOT     = 8'h80;

  localparam logic signed [15:0] NUM_MAX = 16'sd9999;
  localparam logic signed [15:0] NUM_MIN = -16'sd999;

  localparam logic [2:0] BRIGHT_RESET = 3'd1;
  localparam logic       ON_RESET     = 1'b1;

  localparam logic [2:0] BEAT_ADDR  = 3'd1;
  localparam logic [2:0] BEAT_SEG0  = 3'd2;
  localparam logic [2:0] BEAT_LAST  = 3'd5;

  typedef struct packed {
    op_t         operation;
    logic [15:0] number;
    logic        dots;
    logic [31:0] raw_segments;
    logic        turn_on;
    logic [2:0]  brightness;
  } in_t;

  typedef struct packed {
    op_t         operation;
    logic        neg;
    logic [3:0]  thou;
    logic [9:0]  rem;
    logic        dots;
    logic [31:0] raw_segments;
    logic        turn_on;
    logic [2:0]  brightness;
  } mid_t;

  typedef struct packed {
    logic            single;
    logic [3:0][7:0] seg;
    logic [7:0]      ctrl;
    logic [2:0]      bri;
    logic            on;
  } job_t;

  function automatic logic [7:0] seg_lookup(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      4'hF: s = 8'h71;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ssdcf_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ssdcf_in_if;
  import ssdcf_pkg::*;

  logic        valid;
  logic        ready;
  op_t         operation;
  logic signed [15:0] number;
  logic        dots;
  logic [31:0] raw_segments;
  logic        turn_on;
  logic [7:0]  brightness_value;

  modport source (
    output valid, operation, number, dots, raw_segments, turn_on, brightness_value,
    input  ready
  );

  modport sink (
    input  valid, operation, number, dots, raw_segments, turn_on, brightness_value,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/ssdcf_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ssdcf_out_if;

  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       frame_start;
  logic       frame_end;
  logic       last;
  logic [2:0] brightness_now;
  logic       display_on_now;

  modport source (
    output valid, byte_value, frame_start, frame_end, last, brightness_now,
           display_on_now,
    input  ready
  );

  modport sink (
    input  valid, byte_value, frame_start, frame_end, last, brightness_now,
           display_on_now,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/seven_segment_display_command_framer_unit.sv @@
// Command framer for a four-digit seven-segment driver chip.
// in_ch takes one display command per beat: show a clamped signed decimal,
// show four raw segment bytes, set the on/off flag or set the brightness.
// out_ch gives one beat per byte sent to the chip, with frame_start and
// frame_end marking the start and stop conditions around each frame and
// last marking the final byte of a command. Every beat carries the stored
// brightness and on flag as they stand after that command.
// Show commands give six beats (data command frame, then address command
// plus four segment bytes); on/off and brightness give one beat.
// The first beat of a command leaves after three registers in turn:
// an input register, a stage for the thousands digit and a stage for the
// lower digits and the control byte. Beats then leave one per cycle while
// the receiver is ready; the byte sequencer at the output steps through
// the beats of each frame in order.
// While the receiver stalls, the current beat holds and the stages behind
// it fill up; in_ch stays ready until all three stages hold a command.
// Synchronous reset empties all stages and sets brightness 1, display on.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_display_command_framer_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ssdcf_in_if.sink   in_ch,
  ssdcf_out_if.source out_ch
);
  import ssdcf_pkg::*;

  logic       in_valid_r;
  in_t        in_r;
  logic       mid_valid_r;
  mid_t       mid_r;
  logic       job_valid_r;
  job_t       job_r;
  logic [2:0] cnt_r;
  logic [2:0] bri_r;
  logic       on_r;

  logic       in_fire;
  logic       mid_ready;
  logic       mid_fire;
  logic       job_ready;
  logic       beat_done;
  logic       job_done;

  logic signed [15:0] clamp_val;
  logic [13:0] mag;
  mid_t        mid_nxt;

  logic [3:0]  hund;
  logic [6:0]  rem2;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [2:0]  bri_nxt;
  logic        on_nxt;
  job_t        job_nxt;
  logic [2:0]  cnt_nxt;

  logic [7:0]  out_byte;
  logic        out_start;
  logic        out_end;
  logic        out_last;

  // handshakes
  assign beat_done = job_valid_r && out_ch.ready;
  assign job_done  = beat_done && out_last;
  assign job_ready = !job_valid_r || job_done;
  assign mid_fire  = mid_valid_r && job_ready;
  assign mid_ready = !mid_valid_r || job_ready;
  assign in_fire   = in_valid_r && mid_ready;
  assign in_ch.ready = !in_valid_r || mid_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.operation    <= in_ch.operation;
      in_r.number       <= in_ch.number;
      in_r.dots         <= in_ch.dots;
      in_r.raw_segments <= in_ch.raw_segments;
      in_r.turn_on      <= in_ch.turn_on;
      in_r.brightness   <= in_ch.brightness_value[2:0];
    end
  end

  // clamp and thousands digit
  always_comb begin
    if ($signed(in_r.number) > NUM_MAX) begin
      clamp_val = NUM_MAX;
    end else if ($signed(in_r.number) < NUM_MIN) begin
      clamp_val = NUM_MIN;
    end else begin
      clamp_val = $signed(in_r.number);
    end
    mid_nxt.operation    = in_r.operation;
    mid_nxt.dots         = in_r.dots;
    mid_nxt.raw_segments = in_r.raw_segments;
    mid_nxt.turn_on      = in_r.turn_on;
    mid_nxt.brightness   = in_r.brightness;
    mid_nxt.neg          = clamp_val[15];
    mag = clamp_val[15] ? 14'(-clamp_val) : 14'(clamp_val);
    mid_nxt.thou = 4'd0;
    if (!clamp_val[15]) begin
      for (int k = 1; k <= 9; k++) begin
        if (mag >= 14'(k * 1000)) begin
          mid_nxt.thou = 4'(k);
        end
      end
    end
    mid_nxt.rem = 10'(mag - 14'(mid_nxt.thou) * 14'd1000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (mid_ready) begin
      mid_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mid_r <= mid_nxt;
    end
  end

  // lower digits, state update and frame bytes
  always_comb begin
    hund = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (mid_r.rem >= 10'(k * 100)) begin
        hund = 4'(k);
      end
    end
    rem2 = 7'(mid_r.rem - 10'(hund) * 10'd100);
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem2 >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    ones = 4'(rem2 - 7'(tens) * 7'd10);

    bri_nxt = bri_r;
    on_nxt  = on_r;
    job_nxt.single = 1'b0;
    case (mid_r.operation)
      OP_DECIMAL: begin
        job_nxt.seg[0] = mid_r.neg ? SEG_MINUS : seg_lookup(mid_r.thou);
        job_nxt.seg[1] = seg_lookup(hund) | (mid_r.dots ? SEG_DOT : 8'h00);
        job_nxt.seg[2] = seg_lookup(tens);
        job_nxt.seg[3] = seg_lookup(ones);
      end
      OP_RAW: begin
        job_nxt.seg = mid_r.raw_segments;
      end
      OP_POWER: begin
        job_nxt.seg    = mid_r.raw_segments;
        job_nxt.single = 1'b1;
        on_nxt         = mid_r.turn_on;
      end
      OP_BRIGHT: begin
        job_nxt.seg    = mid_r.raw_segments;
        job_nxt.single = 1'b1;
        bri_nxt        = mid_r.brightness;
      end
      default: begin
        job_nxt.seg = mid_r.raw_segments;
      end
    endcase
    job_nxt.ctrl = CMD_DISPLAY | {4'b0000, on_nxt, bri_nxt};
    job_nxt.bri  = bri_nxt;
    job_nxt.on   = on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bri_r <= BRIGHT_RESET;
      on_r  <= ON_RESET;
    end else if (mid_fire) begin
      bri_r <= bri_nxt;
      on_r  <= on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (job_ready) begin
      job_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_fire) begin
      job_r <= job_nxt;
    end
  end

  // byte sequencer
  always_comb begin
    if (job_done || !job_valid_r) begin
      cnt_nxt = 3'd0;
    end else if (beat_done) begin
      cnt_nxt = cnt_r + 3'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    if (job_r.single) begin
      out_byte  = job_r.ctrl;
      out_start = 1'b1;
      out_end   = 1'b1;
      out_last  = 1'b1;
    end else begin
      case (cnt_r)
        3'd0:      out_byte = CMD_DATA;
        BEAT_ADDR: out_byte = CMD_ADDRESS;
        default:   out_byte = job_r.seg[2'(cnt_r - BEAT_SEG0)];
      endcase
      out_start = (cnt_r <= BEAT_ADDR);
      out_end   = (cnt_r == 3'd0) || (cnt_r == BEAT_LAST);
      out_last  = (cnt_r == BEAT_LAST);
    end
  end

  assign out_ch.valid          = job_valid_r;
  assign out_ch.byte_value     = out_byte;
  assign out_ch.frame_start    = out_start;
  assign out_ch.frame_end      = out_end;
  assign out_ch.last           = out_last;
  assign out_ch.brightness_now = job_r.bri;
  assign out_ch.display_on_now = job_r.on;

  assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> cnt_r <= BEAT_LAST)
    else $error("beat counter past last beat");

  assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && job_r.single |-> cnt_r == 3'd0)
    else $error("control frame beyond one beat");

  assert property (@(posedge clk) disable iff (!rst_n)
    beat_done && !out_last |=> job_valid_r && cnt_r == $past(cnt_r) + 3'd1)
    else $error("frame beat skipped or job lost");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(mid_fire && (mid_r.operation == OP_POWER || mid_r.operation == OP_BRIGHT))
    |=> $stable(bri_r) && $stable(on_r))
    else $error("display state changed without control command");

  assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && !beat_done |=> job_valid_r && $stable(cnt_r))
    else $error("stalled beat moved");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ssdcf_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 80;
  localparam int SETTLE      = 20;

  localparam logic [7:0] GLYPH [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct {
    op_t                operation;
    logic signed [15:0] number;
    logic               dots;
    logic [31:0]        raw_segments;
    logic               turn_on;
    logic [7:0]         brightness_value;
  } display_cmd_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
    logic       frame_end;
    logic       last;
    logic [2:0] brightness_now;
    logic       display_on_now;
  } frame_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               cmd_valid      = 1'b0;
  op_t                cmd_op         = OP_DECIMAL;
  logic signed [15:0] cmd_number     = '0;
  logic               cmd_dots       = 1'b0;
  logic [31:0]        cmd_raw        = '0;
  logic               cmd_turn_on    = 1'b0;
  logic [7:0]         cmd_brightness = '0;
  logic               rx_ready       = 1'b0;

  ssdcf_in_if  cmd_if ();
  ssdcf_out_if frame_if ();

  assign cmd_if.valid            = cmd_valid;
  assign cmd_if.operation        = cmd_op;
  assign cmd_if.number           = cmd_number;
  assign cmd_if.dots             = cmd_dots;
  assign cmd_if.raw_segments     = cmd_raw;
  assign cmd_if.turn_on          = cmd_turn_on;
  assign cmd_if.brightness_value = cmd_brightness;
  assign frame_if.ready          = rx_ready;

  seven_segment_display_command_framer_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (frame_if)
  );

  display_cmd_t pending_cmds[$];
  display_cmd_t cur_cmd;
  frame_beat_t  expected_beats[$];

  logic [2:0] stored_bright = BRIGHT_RESET;
  logic       stored_on     = ON_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int beats_checked = 0;
  int stall_cycles  = 0;
  int op_count [4]  = '{0, 0, 0, 0};

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic push_beat(input logic [7:0] b, input logic is_start, input logic is_stop,
                           input logic is_last);
    frame_beat_t beat;
    beat.byte_value     = b;
    beat.frame_start    = is_start;
    beat.frame_end      = is_stop;
    beat.last           = is_last;
    beat.brightness_now = stored_bright;
    beat.display_on_now = stored_on;
    expected_beats.push_back(beat);
  endtask

  task automatic frame_command(input display_cmd_t c);
    int          n;
    int unsigned mag;
    logic [7:0]  seg [4];
    case (c.operation)
      OP_DECIMAL: begin
        n = int'(c.number);
        if (n > NUM_MAX) n = NUM_MAX;
        else if (n < NUM_MIN) n = NUM_MIN;
        if (n < 0) begin
          seg[0] = SEG_MINUS;
          mag = -n;
        end else begin
          mag = n;
          seg[0] = GLYPH[mag / 1000];
          mag = mag % 1000;
        end
        seg[1] = GLYPH[mag / 100] | (c.dots ? SEG_DOT : 8'h00);
        mag = mag % 100;
        seg[2] = GLYPH[mag / 10];
        seg[3] = GLYPH[mag % 10];
      end
      OP_RAW: begin
        for (int i = 0; i < 4; i++) seg[i] = c.raw_segments[8*i +: 8];
      end
      OP_POWER:  stored_on = c.turn_on;
      OP_BRIGHT: stored_bright = c.brightness_value[2:0];
      default: ;
    endcase
    if (c.operation == OP_DECIMAL || c.operation == OP_RAW) begin
      push_beat(CMD_DATA, 1'b1, 1'b1, 1'b0);
      push_beat(CMD_ADDRESS, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) push_beat(seg[i], 1'b0, i == 3, i == 3);
    end else begin
      push_beat(CMD_DISPLAY | {4'b0, stored_on, stored_bright}, 1'b1, 1'b1, 1'b1);
    end
  endtask

  function automatic display_cmd_t make_cmd(input op_t op, input int num, input logic dots,
                                            input logic [31:0] raw, input logic on,
                                            input logic [7:0] bri);
    display_cmd_t c;
    c.operation        = op;
    c.number           = num[15:0];
    c.dots             = dots;
    c.raw_segments     = raw;
    c.turn_on          = on;
    c.brightness_value = bri;
    return c;
  endfunction

  function automatic display_cmd_t random_cmd();
    int num;
    case ($urandom_range(5))
      0: num = $urandom_range(16'hFFFF);
      1: num = $urandom_range(9999);
      2: num = -$urandom_range(999);
      3: num = $urandom_range(9) + (($urandom_range(1) == 1) ? 9995 : -1004);
      4: num = $urandom_range(99);
      default: num = -$urandom_range(32768, 1000);
    endcase
    return make_cmd(op_t'($urandom_range(3)), num, 1'($urandom_range(1)), $urandom(),
                    1'($urandom_range(1)), 8'($urandom_range(255)));
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_beats.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_if.ready) begin
        frame_command(cur_cmd);
        op_count[cur_cmd.operation]++;
      end
      if (!cmd_valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_valid      <= 1'b1;
          cmd_op         <= cur_cmd.operation;
          cmd_number     <= cur_cmd.number;
          cmd_dots       <= cur_cmd.dots;
          cmd_raw        <= cur_cmd.raw_segments;
          cmd_turn_on    <= cur_cmd.turn_on;
          cmd_brightness <= cur_cmd.brightness_value;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // monitor and receiver
  always @(posedge clk) begin
    frame_beat_t exp_beat;
    if (!rst_n) begin
      rx_ready  <= 1'b0;
      hold_left <= 0;
    end else begin
      if (frame_if.valid && rx_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: byte_value 0x%0h", frame_if.byte_value);
          mismatches++;
        end else begin
          exp_beat = expected_beats.pop_front();
          check_field("byte_value", 32'(exp_beat.byte_value), 32'(frame_if.byte_value));
          check_field("frame_start", 32'(exp_beat.frame_start), 32'(frame_if.frame_start));
          check_field("frame_end", 32'(exp_beat.frame_end), 32'(frame_if.frame_end));
          check_field("last", 32'(exp_beat.last), 32'(frame_if.last));
          check_field("brightness_now", 32'(exp_beat.brightness_now),
                      32'(frame_if.brightness_now));
          check_field("display_on_now", 32'(exp_beat.display_on_now),
                      32'(frame_if.display_on_now));
          beats_checked++;
        end
      end
      if (hold_served != hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left   <= LONG_HOLD;
        rx_ready    <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rx_ready  <= 1'b0;
      end else begin
        rx_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_valid && cmd_if.ready) || (frame_if.valid && rx_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clamp edges, signs, dots, raw extremes, state updates
    send_idle_pct = 17;
    recv_idle_pct = 78;
    pending_cmds.push_back(make_cmd(OP_DECIMAL, 0, 1'b0, '0, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, 9999, 1'b0, '1, 1'b1, 8'hFF));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, 10000, 1'b1, '0, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, 32767, 1'b0, '0, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, -999, 1'b0, '0, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, -1000, 1'b1, '0, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, -32768, 1'b0, '1, 1'b1, 8'hFF));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, -1, 1'b1, '0, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, 1234, 1'b1, '0, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, 8, 1'b0, '0, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_RAW, 0, 1'b0, 32'h0000_0000, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_RAW, -1, 1'b1, 32'hFFFF_FFFF, 1'b1, 8'hFF));
    pending_cmds.push_back(make_cmd(OP_RAW, 5678, 1'b1, 32'h1234_5678, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_POWER, -1, 1'b1, '1, 1'b0, 8'hFF));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, 42, 1'b0, '0, 1'b1, 8'h07));
    pending_cmds.push_back(make_cmd(OP_POWER, 0, 1'b0, '0, 1'b1, 8'h00));
    pending_cmds.push_back(make_cmd(OP_BRIGHT, 0, 1'b1, '1, 1'b0, 8'h00));
    pending_cmds.push_back(make_cmd(OP_BRIGHT, 0, 1'b0, '0, 1'b1, 8'h07));
    pending_cmds.push_back(make_cmd(OP_BRIGHT, 0, 1'b0, '0, 1'b0, 8'hFF));
    pending_cmds.push_back(make_cmd(OP_BRIGHT, 0, 1'b0, '0, 1'b0, 8'hF8));
    pending_cmds.push_back(make_cmd(OP_BRIGHT, 0, 1'b0, '0, 1'b0, 8'h03));
    pending_cmds.push_back(make_cmd(OP_DECIMAL, -50, 1'b1, '0, 1'b0, 8'h00));
    drain();

    for (int i = 0; i < 80; i++) pending_cmds.push_back(random_cmd());
    drain();

    send_idle_pct = 78;
    recv_idle_pct = 17;
    for (int i = 0; i < 60; i++) pending_cmds.push_back(random_cmd());
    drain();

    // hold the receiver off while commands keep coming, so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = hold_requests + 1;
    for (int i = 0; i < 60; i++) pending_cmds.push_back(random_cmd());
    drain();

    repeat (SETTLE) @(negedge clk);
    if (expected_beats.size() != 0) begin
      $error("%0d expected beats never arrived", expected_beats.size());
    end
    $display("testbench: %0d decimal, %0d raw, %0d on/off, %0d brightness commands",
             op_count[OP_DECIMAL], op_count[OP_RAW], op_count[OP_POWER], op_count[OP_BRIGHT]);
    $display("testbench: %0d frame beats checked across three idle mixes and a long stall",
             beats_checked);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
